/* rtl/core/rs485uf_pkg.sv */
// ----------------------------------------------------------------------------
// RS485 UART FIFO controller package
// Operation codes, default queue depth and shared constants.
// ----------------------------------------------------------------------------
package rs485uf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned FUNC_W          = 3;
  localparam int unsigned BYTE_W          = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT      = 3'd0,
    FUNC_GET      = 3'd1,
    FUNC_TX_READY = 3'd2,
    FUNC_RX_BYTE  = 3'd3,
    FUNC_POLL     = 3'd4
  } func_t;

endpackage

/* rtl/core/rs485uf_if.sv */
// ----------------------------------------------------------------------------
// RS485 UART FIFO controller channels
// Request channel and result channel, valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface rs485uf_in_if
  import rs485uf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] data;
  logic              partner_sending;

  modport source (output valid, func, data, partner_sending, input ready);
  modport sink   (input valid, func, data, partner_sending, output ready);
endinterface

interface rs485uf_out_if
  import rs485uf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [BYTE_W-1:0] read_data;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              dir_transmit;
  logic              start_tx;

  modport source (output valid, ok, read_data, tx_valid, tx_byte, dir_transmit, start_tx,
                  input ready);
  modport sink   (input valid, ok, read_data, tx_valid, tx_byte, dir_transmit, start_tx,
                  output ready);
endinterface

/* rtl/core/rs485uf_ram.sv */
// ----------------------------------------------------------------------------
// RS485 UART FIFO controller RAM
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rs485uf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rs485_uart_fifo_controller.sv */
// ----------------------------------------------------------------------------
// RS485 UART FIFO controller
// Transmit and receive ring-buffer queues with RS485 driver direction control.
//
//   channel    role    handshake        payload
//   in_chan    sink    valid / ready    func, data, partner_sending
//   out_chan   source  valid / ready    ok, read_data, tx_valid, tx_byte,
//                                       dir_transmit, start_tx
//
// One request per cycle while in_chan.ready is high, one result per request:
// queue pointers update and the queue RAM is accessed at acceptance, the
// RAM read register and the result register follow.
// Synchronous reset clears pointers, fill counts, direction and valid flags;
// queue contents are not cleared and no clearing pass runs.
// A stalled result holds the stage behind it, and in_chan.ready drops once
// both stages are full.
// ----------------------------------------------------------------------------
module rs485_uart_fifo_controller
  import rs485uf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rs485uf_in_if.sink      in_chan,
  rs485uf_out_if.source   out_chan
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  logic [PTR_W-1:0]  tx_wr_ptr_r, tx_wr_ptr_nxt;
  logic [PTR_W-1:0]  tx_rd_ptr_r, tx_rd_ptr_nxt;
  logic [FILL_W-1:0] tx_fill_r, tx_fill_nxt;
  logic [PTR_W-1:0]  rx_wr_ptr_r, rx_wr_ptr_nxt;
  logic [PTR_W-1:0]  rx_rd_ptr_r, rx_rd_ptr_nxt;
  logic [FILL_W-1:0] rx_fill_r, rx_fill_nxt;
  logic              tx_active_r, tx_active_nxt;
  logic              dir_r, dir_nxt;

  logic              tx_we, tx_re, rx_we, rx_re;
  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data;

  logic              ok_nxt, start_nxt;

  logic              a_valid_r, a_ok_r, a_rx_pop_r, a_tx_pop_r, a_dir_r, a_start_r;
  logic              b_valid_r, b_ok_r, b_tx_valid_r, b_dir_r, b_start_r;
  logic [BYTE_W-1:0] b_read_data_r, b_tx_byte_r;

  logic              b_load, in_acc;

  assign b_load        = !b_valid_r || out_chan.ready;
  assign in_chan.ready = !a_valid_r || b_load;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    tx_wr_ptr_nxt = tx_wr_ptr_r;
    tx_rd_ptr_nxt = tx_rd_ptr_r;
    tx_fill_nxt   = tx_fill_r;
    rx_wr_ptr_nxt = rx_wr_ptr_r;
    rx_rd_ptr_nxt = rx_rd_ptr_r;
    rx_fill_nxt   = rx_fill_r;
    tx_active_nxt = tx_active_r;
    dir_nxt       = dir_r;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    ok_nxt        = 1'b0;
    start_nxt     = 1'b0;
    if (in_acc) begin
      case (func_t'(in_chan.func))
        FUNC_PUT: begin
          if (tx_fill_r != FILL_FULL) begin
            if (!tx_active_r) begin
              tx_active_nxt = 1'b1;
              dir_nxt       = 1'b1;
              start_nxt     = 1'b1;
            end
            tx_we         = 1'b1;
            tx_wr_ptr_nxt = ptr_step(tx_wr_ptr_r);
            tx_fill_nxt   = tx_fill_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        FUNC_GET: begin
          if (rx_fill_r != '0) begin
            rx_re         = 1'b1;
            rx_rd_ptr_nxt = ptr_step(rx_rd_ptr_r);
            rx_fill_nxt   = rx_fill_r - 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        FUNC_TX_READY: begin
          if (tx_fill_r != '0) begin
            tx_re         = 1'b1;
            tx_rd_ptr_nxt = ptr_step(tx_rd_ptr_r);
            tx_fill_nxt   = tx_fill_r - 1'b1;
          end else begin
            tx_active_nxt = 1'b0;
            dir_nxt       = 1'b0;
          end
          ok_nxt = 1'b1;
        end
        FUNC_RX_BYTE: begin
          if (rx_fill_r != FILL_FULL) begin
            rx_we         = 1'b1;
            rx_wr_ptr_nxt = ptr_step(rx_wr_ptr_r);
            rx_fill_nxt   = rx_fill_r + 1'b1;
            ok_nxt        = 1'b1;
          end
        end
        FUNC_POLL: begin
          if (!in_chan.partner_sending && tx_fill_r != '0 && !tx_active_r) begin
            tx_active_nxt = 1'b1;
            dir_nxt       = 1'b1;
            start_nxt     = 1'b1;
          end
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  rs485uf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_wr_ptr_r),
    .wr_data (in_chan.data),
    .rd_en   (tx_re),
    .rd_addr (tx_rd_ptr_r),
    .rd_data (tx_rd_data)
  );

  rs485uf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_wr_ptr_r),
    .wr_data (in_chan.data),
    .rd_en   (rx_re),
    .rd_addr (rx_rd_ptr_r),
    .rd_data (rx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      tx_fill_r   <= '0;
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      rx_fill_r   <= '0;
      tx_active_r <= 1'b0;
      dir_r       <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      tx_wr_ptr_r <= tx_wr_ptr_nxt;
      tx_rd_ptr_r <= tx_rd_ptr_nxt;
      tx_fill_r   <= tx_fill_nxt;
      rx_wr_ptr_r <= rx_wr_ptr_nxt;
      rx_rd_ptr_r <= rx_rd_ptr_nxt;
      rx_fill_r   <= rx_fill_nxt;
      tx_active_r <= tx_active_nxt;
      dir_r       <= dir_nxt;
      if (in_chan.ready) begin
        a_valid_r <= in_chan.valid;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_ok_r     <= ok_nxt;
      a_rx_pop_r <= rx_re;
      a_tx_pop_r <= tx_re;
      a_dir_r    <= dir_nxt;
      a_start_r  <= start_nxt;
    end
    if (b_load && a_valid_r) begin
      b_ok_r        <= a_ok_r;
      b_read_data_r <= a_rx_pop_r ? rx_rd_data : '0;
      b_tx_valid_r  <= a_tx_pop_r;
      b_tx_byte_r   <= a_tx_pop_r ? tx_rd_data : '0;
      b_dir_r       <= a_dir_r;
      b_start_r     <= a_start_r;
    end
  end

  assign out_chan.valid        = b_valid_r;
  assign out_chan.ok           = b_ok_r;
  assign out_chan.read_data    = b_read_data_r;
  assign out_chan.tx_valid     = b_tx_valid_r;
  assign out_chan.tx_byte      = b_tx_byte_r;
  assign out_chan.dir_transmit = b_dir_r;
  assign out_chan.start_tx     = b_start_r;

  a_dir_follows_active: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r == tx_active_r)
    else $error("driver direction differs from transmitter activity");

  a_tx_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_fill_r <= FILL_FULL) && ((tx_fill_r != '0) || (tx_wr_ptr_r == tx_rd_ptr_r)))
    else $error("transmit queue fill out of step with pointers");

  a_rx_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r <= FILL_FULL) && ((rx_fill_r != '0) || (rx_wr_ptr_r == rx_rd_ptr_r)))
    else $error("receive queue fill out of step with pointers");

  a_start_drives: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.start_tx) |-> (out_chan.dir_transmit && out_chan.ok))
    else $error("transmitter start without transmit direction");

endmodule

/* test/rs485_uart_fifo_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RS485 UART FIFO controller testbench
// Sends put, get, transmitter-ready, receive, drive-poll and unused-code
// requests with random gaps, and stalls the result channel at random, with
// one long hold-off. A built-in queue predictor supplies the expected result
// of each request, and every result is compared with it in order.
// ----------------------------------------------------------------------------
module rs485_uart_fifo_controller_tb;
  import rs485uf_pkg::*;

  localparam int unsigned          DEPTH          = QUEUE_DEPTH_DEF;
  localparam int unsigned          RANDOM_COUNT   = 850;
  localparam int unsigned          CYCLE_LIMIT    = 400000;
  localparam int unsigned          HOLD_AT        = 300;
  localparam int unsigned          HOLD_CYCLES    = 150;
  localparam int unsigned          MAX_REPORTS    = 10;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_HI = 3'd7;

  typedef enum int {
    SEG_TX_FILL,
    SEG_TX_DRAIN,
    SEG_RX_FILL,
    SEG_RX_DRAIN,
    SEG_MIXED,
    SEG_NOISE
  } segment_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic              partner;
    int unsigned       gap;
  } uart_req_t;

  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] read_data;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              dir_transmit;
    logic              start_tx;
  } uart_result_t;

  logic clk;
  logic rst_n;

  rs485uf_in_if  in_chan ();
  rs485uf_out_if out_chan ();

  rs485_uart_fifo_controller #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  uart_req_t    request_queue[$];
  uart_result_t pending_results[$];

  logic [BYTE_W-1:0] tx_ring[DEPTH];
  logic [BYTE_W-1:0] rx_ring[DEPTH];
  int unsigned       tx_wr, tx_rd, tx_count;
  int unsigned       rx_wr, rx_rd, rx_count;
  logic              tx_running;
  logic              drive_tx;

  int unsigned total_reqs;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  logic        hold_active;
  logic        hold_done;
  uart_req_t   next_req;

  int unsigned tx_full_hits, rx_full_hits, empty_gets, tx_sent, start_cnt, ignored_cnt;

  task automatic apply_uart_op(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                               input logic partner);
    uart_result_t res;
    res = '0;
    case (func)
      FUNC_PUT: begin
        if (tx_count < DEPTH) begin
          if (!tx_running) begin
            tx_running = 1'b1;
            drive_tx = 1'b1;
            res.start_tx = 1'b1;
          end
          tx_ring[tx_wr] = data;
          tx_wr = (tx_wr + 1) % DEPTH;
          tx_count++;
          res.ok = 1'b1;
        end else begin
          tx_full_hits++;
        end
      end
      FUNC_GET: begin
        if (rx_count != 0) begin
          res.read_data = rx_ring[rx_rd];
          rx_rd = (rx_rd + 1) % DEPTH;
          rx_count--;
          res.ok = 1'b1;
        end else begin
          empty_gets++;
        end
      end
      FUNC_TX_READY: begin
        if (tx_count != 0) begin
          res.tx_byte = tx_ring[tx_rd];
          res.tx_valid = 1'b1;
          tx_rd = (tx_rd + 1) % DEPTH;
          tx_count--;
          tx_sent++;
        end else begin
          tx_running = 1'b0;
          drive_tx = 1'b0;
        end
        res.ok = 1'b1;
      end
      FUNC_RX_BYTE: begin
        if (rx_count < DEPTH) begin
          rx_ring[rx_wr] = data;
          rx_wr = (rx_wr + 1) % DEPTH;
          rx_count++;
          res.ok = 1'b1;
        end else begin
          rx_full_hits++;
        end
      end
      FUNC_POLL: begin
        if (!partner && tx_count > 0 && !tx_running) begin
          tx_running = 1'b1;
          drive_tx = 1'b1;
          res.start_tx = 1'b1;
        end
        res.ok = 1'b1;
      end
      default: ignored_cnt++;
    endcase
    res.dir_transmit = drive_tx;
    if (res.start_tx) start_cnt++;
    pending_results.push_back(res);
  endtask

  task automatic add_req(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] data,
                         input logic partner, input int unsigned gap);
    uart_req_t req;
    req.func = func;
    req.data = data;
    req.partner = partner;
    req.gap = gap;
    request_queue.push_back(req);
  endtask

  function automatic logic [FUNC_W-1:0] pick_func(input segment_t seg);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (seg)
      SEG_TX_FILL:
        return (r < 88) ? FUNC_PUT : (r < 93) ? FUNC_RX_BYTE : (r < 97) ? FUNC_GET : FUNC_POLL;
      SEG_TX_DRAIN:
        return (r < 60) ? FUNC_TX_READY : (r < 75) ? FUNC_PUT : (r < 85) ? FUNC_GET :
               (r < 95) ? FUNC_RX_BYTE : FUNC_POLL;
      SEG_RX_FILL:
        return (r < 88) ? FUNC_RX_BYTE : (r < 93) ? FUNC_PUT : (r < 97) ? FUNC_TX_READY :
               FUNC_POLL;
      SEG_RX_DRAIN:
        return (r < 60) ? FUNC_GET : (r < 75) ? FUNC_RX_BYTE : (r < 85) ? FUNC_TX_READY :
               (r < 95) ? FUNC_PUT : FUNC_POLL;
      SEG_MIXED:
        return FUNC_W'($urandom_range(FUNC_PUT, FUNC_POLL));
      default:
        return FUNC_W'($urandom_range(FUNC_PUT, FUNC_UNUSED_HI));
    endcase
  endfunction

  task automatic build_requests();
    int unsigned counted;
    int unsigned seg_len;
    int unsigned pick;
    segment_t    seg;
    logic        burst;
    logic [FUNC_W-1:0] f;
    add_req(FUNC_GET, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_TX_READY, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_POLL, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_POLL, 8'hFF, 1'b1, $urandom_range(0, 9));
    add_req(FUNC_PUT, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_PUT, 8'hFF, 1'b1, $urandom_range(0, 9));
    add_req(FUNC_PUT, 8'hA5, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_POLL, 8'h00, 1'b0, $urandom_range(0, 9));
    repeat (4) add_req(FUNC_TX_READY, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_RX_BYTE, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_RX_BYTE, 8'hFF, 1'b1, $urandom_range(0, 9));
    add_req(FUNC_RX_BYTE, 8'h5A, 1'b0, $urandom_range(0, 9));
    repeat (4) add_req(FUNC_GET, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_UNUSED_LO, 8'hFF, 1'b1, $urandom_range(0, 9));
    add_req(FUNC_UNUSED_LO + 3'd1, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_UNUSED_HI, 8'h3C, 1'b1, $urandom_range(0, 9));
    add_req(FUNC_PUT, 8'h3C, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_TX_READY, 8'h00, 1'b0, $urandom_range(0, 9));
    add_req(FUNC_TX_READY, 8'h00, 1'b0, $urandom_range(0, 9));

    counted = 0;
    while (counted < RANDOM_COUNT) begin
      pick = $urandom_range(0, 9);
      seg = (pick < 2) ? SEG_TX_FILL : (pick < 4) ? SEG_TX_DRAIN : (pick < 6) ? SEG_RX_FILL :
            (pick < 8) ? SEG_RX_DRAIN : (pick < 9) ? SEG_MIXED : SEG_NOISE;
      seg_len = (seg == SEG_TX_FILL || seg == SEG_RX_FILL) ? $urandom_range(70, 100) :
                $urandom_range(10, 60);
      burst = ($urandom_range(0, 2) == 0);
      repeat (seg_len) begin
        f = pick_func(seg);
        add_req(f, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                burst ? 0 : $urandom_range(0, 9));
        if (f < FUNC_UNUSED_LO) counted++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      accepted_cnt <= 0;
      gap_left <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        apply_uart_op(in_chan.func, in_chan.data, in_chan.partner_sending);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (gap_left != 0) begin
        in_chan.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_queue.size() != 0) begin
        next_req = request_queue.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.func <= next_req.func;
        in_chan.data <= next_req.data;
        in_chan.partner_sending <= next_req.partner;
        gap_left <= next_req.gap;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (hold_active) begin
      if (hold_left == 1) hold_active <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_active <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(posedge clk) begin
    uart_result_t got, want;
    int unsigned  next_stall;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      checked_cnt <= 0;
      stall_left <= 0;
    end else begin
      next_stall = stall_left;
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.ok, out_chan.read_data, out_chan.tx_valid, out_chan.tx_byte,
               out_chan.dir_transmit, out_chan.start_tx};
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] result with no request outstanding: %p", $realtime, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display({"[%0t] result %0d: expected ok=%b rd=%h txv=%b txb=%h dir=%b st=%b,",
                        " got ok=%b rd=%h txv=%b txb=%h dir=%b st=%b"}, $realtime, checked_cnt,
                       want.ok, want.read_data, want.tx_valid, want.tx_byte,
                       want.dir_transmit, want.start_tx, got.ok, got.read_data,
                       got.tx_valid, got.tx_byte, got.dir_transmit, got.start_tx);
          end
        end
        checked_cnt <= checked_cnt + 1;
        next_stall = ((checked_cnt / 128) % 3 == 1) ? 0 : $urandom_range(0, 9);
      end
      if (next_stall > 0) begin
        out_chan.ready <= 1'b0;
        stall_left <= next_stall - 1;
      end else begin
        out_chan.ready <= !hold_active;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests accepted",
               cycle_cnt, accepted_cnt, total_reqs);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cycle_cnt = 0;
    fail_cnt = 0;
    in_chan.valid = 1'b0;
    in_chan.func = FUNC_PUT;
    in_chan.data = '0;
    in_chan.partner_sending = 1'b0;
    out_chan.ready = 1'b0;
    tx_wr = 0; tx_rd = 0; tx_count = 0;
    rx_wr = 0; rx_rd = 0; rx_count = 0;
    tx_running = 1'b0;
    drive_tx = 1'b0;
    tx_full_hits = 0; rx_full_hits = 0; empty_gets = 0;
    tx_sent = 0; start_cnt = 0; ignored_cnt = 0;
    build_requests();
    total_reqs = request_queue.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (accepted_cnt != total_reqs || checked_cnt != accepted_cnt) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("%0d requests (%0d ignored codes), %0d bytes sent, %0d transmitter starts",
             total_reqs, ignored_cnt, tx_sent, start_cnt);
    $display("transmit-full rejects %0d, receive-full drops %0d, empty gets %0d",
             tx_full_hits, rx_full_hits, empty_gets);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
